// ===== src/rdm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the reverse depth map block
// no dependencies

package rdm_pkg;

  localparam int COLOR_PIXELS = 2097152;
  localparam int DEPTH_PIXELS = 262144;
  localparam int COLOR_AW     = $clog2(COLOR_PIXELS);

  localparam int LIMIT_W = 22;
  localparam int PIX_W   = 18;
  localparam int MM_W    = 16;
  localparam int SLOT_W  = 22;
  localparam int MAP_W   = 19;

  // word layout in the map memory: {valid, depth in mm, depth pixel}
  localparam int ENTRY_W = 1 + MM_W + PIX_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 22'd2073600;
  localparam logic [LIMIT_W:0]   COLOR_PIXELS_W  = 23'(COLOR_PIXELS);
  localparam logic [20:0]        DEPTH_PIXELS_W  = 21'(DEPTH_PIXELS);
  localparam logic [COLOR_AW-1:0] SWEEP_LAST     = COLOR_AW'(COLOR_PIXELS - 1);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_SCATTER = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load_item;    // capture an accepted input transaction
    logic sweep_start;  // reset the sweep address
    logic sweep_step;   // write an empty entry at the sweep address
    logic result_load;  // commit the entry update and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
    logic op_clear;
  } ctrl_status_t;

endpackage

// ===== src/rdm_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module rdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rdm_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the reverse depth map
// depends on rdm_pkg

module rdm_ctrl import rdm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    cmd.load_item   = 1'b0;
    cmd.sweep_start = 1'b0;
    cmd.sweep_step  = 1'b0;
    cmd.result_load = 1'b0;
    case (state)
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item   = 1'b1;
          cmd.sweep_start = 1'b1;
          state_next      = status.op_clear ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // hold here until the result register can take the result
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_UPD;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

endmodule

// ===== src/rdm_datapath.sv =====
`timescale 1ns / 1ps
// datapath: item registers, map memory, compare logic and result register
// depends on rdm_pkg and rdm_ram

module rdm_datapath import rdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output ctrl_status_t             status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIMIT_W-1:0]       cfg_data,
  input  logic [1:0]               opcode,
  input  logic [PIX_W-1:0]         depth_pixel,
  input  logic signed [SLOT_W-1:0] color_slot,
  input  logic [MM_W-1:0]          depth_value,
  input  logic                     depth_finite,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     updated,
  output logic                     found,
  output logic signed [MAP_W-1:0]  mapped_depth_pixel
);

  logic [LIMIT_W-1:0]  limit;
  opcode_t             op;
  logic [PIX_W-1:0]    pix;
  logic [SLOT_W-1:0]   slot;
  logic [MM_W-1:0]     depth;
  logic                finite;
  logic [COLOR_AW-1:0] sweep_addr;

  logic                ram_we;
  logic [COLOR_AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                slot_ok;
  logic                scatter_ok;
  logic                ent_valid;
  logic [MM_W-1:0]     ent_mm;
  logic [PIX_W-1:0]    ent_pix;
  logic                upd;
  logic                hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op     <= opcode_t'(opcode);
      pix    <= depth_pixel;
      slot   <= color_slot;
      depth  <= depth_value;
      finite <= depth_finite;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_step) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // negative slots carry the sign bit, so the unsigned compares stay clean
  assign slot_ok = !slot[SLOT_W-1] && (slot < limit) && ({1'b0, slot} < COLOR_PIXELS_W);
  assign scatter_ok = (op == OP_SCATTER) && slot_ok && ({3'b000, pix} < DEPTH_PIXELS_W)
                      && finite && (depth != '0);

  assign ent_valid = ram_rdata[ENTRY_W-1];
  assign ent_mm    = ram_rdata[PIX_W +: MM_W];
  assign ent_pix   = ram_rdata[PIX_W-1:0];

  // ties keep the earlier pixel
  assign upd = scatter_ok && (!ent_valid || (depth < ent_mm));
  assign hit = (op == OP_LOOKUP) && slot_ok && ent_valid;

  assign ram_we    = cmd.sweep_step || (cmd.result_load && upd);
  assign ram_waddr = cmd.sweep_step ? sweep_addr : slot[COLOR_AW-1:0];
  assign ram_wdata = cmd.sweep_step ? '0 : {1'b1, depth, pix};

  rdm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (COLOR_PIXELS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot[COLOR_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      updated            <= upd;
      found              <= hit;
      mapped_depth_pixel <= hit ? signed'({1'b0, ent_pix}) : '1;
    end
  end

  assign status.sweep_last = (sweep_addr == SWEEP_LAST);
  assign status.out_free   = !out_valid || out_ready;
  assign status.op_clear   = (opcode_t'(opcode) == OP_CLEAR);

endmodule

// ===== src/reverse_depth_map_min_scatter.sv =====
`timescale 1ns / 1ps
// color-to-depth reverse map, minimum depth wins per color entry
// scatter and lookup: accept, memory read, then compare/write, which holds while the result
//   register is full; a new item is accepted only after the result is loaded, limited by the
//   read-modify-write on the map memory
// clear: one entry emptied per cycle by the sweep, then the result is loaded
// reset: synchronous; a sweep empties the map, in_ready low meanwhile
// depends on rdm_pkg, rdm_ctrl, rdm_datapath

module reverse_depth_map_min_scatter import rdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIMIT_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [PIX_W-1:0]         depth_pixel,
  input  logic signed [SLOT_W-1:0] color_slot,
  input  logic [MM_W-1:0]          depth_value,
  input  logic                     depth_finite,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     updated,
  output logic                     found,
  output logic signed [MAP_W-1:0]  mapped_depth_pixel
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  rdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rdm_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .opcode             (opcode),
    .depth_pixel        (depth_pixel),
    .color_slot         (color_slot),
    .depth_value        (depth_value),
    .depth_finite       (depth_finite),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .updated            (updated),
    .found              (found),
    .mapped_depth_pixel (mapped_depth_pixel)
  );

  // no new transaction while the map is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |-> !in_ready)
    else $error("input accepted during map sweep");

  // one item at a time: after an accept the input side closes
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accept");

  // each item commits its result exactly once
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> !cmd.result_load)
    else $error("result committed twice");

  // a result never reports both an update and a hit, and a hit is never -1
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(updated && found) && (!found || !mapped_depth_pixel[MAP_W-1])))
    else $error("inconsistent result fields");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for reverse_depth_map_min_scatter: directed clear, scatter, lookup, nop and random
// scatter, lookup, nop items vs a minimum-depth map tracker, random idling on both channels
// depends on rdm_pkg and the reverse_depth_map_min_scatter rtl

module tb_top;
  import rdm_pkg::*;

  localparam int SLOT_TOP = COLOR_PIXELS - 1;

  typedef struct packed {
    opcode_t              op;
    logic [PIX_W-1:0]     pix;
    logic [SLOT_W-1:0]    slot;
    logic [MM_W-1:0]      mm;
    logic                 finite;
  } map_item_t;

  typedef struct packed {
    logic                    updated;
    logic                    found;
    logic signed [MAP_W-1:0] mapped;
  } map_result_t;

  // keeps its own copy of the map and the limit, queues the result each transaction should give
  class reverse_map_tracker;
    bit                occupied [int];
    bit [PIX_W-1:0]    owner_pixel [int];
    bit [MM_W-1:0]     owner_mm [int];
    bit [LIMIT_W-1:0]  pixel_limit = LIMIT_RESET;
    map_result_t       expected_results [$];
    int                mismatches;

    function void set_limit(logic [LIMIT_W-1:0] value);
      pixel_limit = value;
    endfunction

    // map entry of a slot, -1 when negative, past the limit or past the map
    function int entry_of(logic [SLOT_W-1:0] slot);
      if (slot[SLOT_W-1]) return -1;
      if (slot >= pixel_limit || int'(slot) >= COLOR_PIXELS) return -1;
      return int'(slot);
    endfunction

    function void note_item(opcode_t op, logic [PIX_W-1:0] pix, logic [SLOT_W-1:0] slot,
                            logic [MM_W-1:0] mm, logic finite);
      map_result_t res;
      int idx;
      res = '{updated: 1'b0, found: 1'b0, mapped: '1};
      idx = entry_of(slot);
      case (op)
        OP_CLEAR: begin
          occupied.delete();
        end
        OP_SCATTER: begin
          if (idx >= 0 && int'(pix) < DEPTH_PIXELS && finite && mm != '0) begin
            // strictly nearer wins, ties keep the earlier pixel
            if (!occupied.exists(idx) || mm < owner_mm[idx]) begin
              occupied[idx]    = 1'b1;
              owner_pixel[idx] = pix;
              owner_mm[idx]    = mm;
              res.updated      = 1'b1;
            end
          end
        end
        OP_LOOKUP: begin
          if (idx >= 0 && occupied.exists(idx)) begin
            res.found  = 1'b1;
            res.mapped = {1'b0, owner_pixel[idx]};
          end
        end
        default: ;
      endcase
      expected_results = {expected_results, res};
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
        $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
    endtask

    task check_result(logic upd, logic fnd, logic signed [MAP_W-1:0] mapped);
      map_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", 32'(mapped), '0);
        return;
      end
      want = expected_results.pop_front();
      if (upd !== want.updated) report_mismatch("updated", 32'(upd), 32'(want.updated));
      if (fnd !== want.found) report_mismatch("found", 32'(fnd), 32'(want.found));
      if (mapped !== want.mapped)
        report_mismatch("mapped_depth_pixel", 32'(mapped), 32'(want.mapped));
    endtask
  endclass

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [LIMIT_W-1:0]       cfg_data     = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic [1:0]               opcode       = '0;
  logic [PIX_W-1:0]         depth_pixel  = '0;
  logic signed [SLOT_W-1:0] color_slot   = '0;
  logic [MM_W-1:0]          depth_value  = '0;
  logic                     depth_finite = 1'b0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic                     updated;
  logic                     found;
  logic signed [MAP_W-1:0]  mapped_depth_pixel;

  reverse_map_tracker tracker;
  bit gaps_on = 1'b1;
  int cur_limit = LIMIT_RESET;
  int phase_limits [6];

  reverse_depth_map_min_scatter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .depth_pixel(depth_pixel),
    .color_slot(color_slot),
    .depth_value(depth_value),
    .depth_finite(depth_finite),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .updated(updated),
    .found(found),
    .mapped_depth_pixel(mapped_depth_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd200_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // receiver stalls
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= !gaps_on || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_limit(cfg_data);
      if (in_valid && in_ready)
        tracker.note_item(opcode_t'(opcode), depth_pixel, color_slot, depth_value, depth_finite);
      if (out_valid && out_ready) tracker.check_result(updated, found, mapped_depth_pixel);
    end
  end

  function automatic map_item_t map_op(opcode_t op, int slot, int pix = 0, int mm = 0,
                                       bit finite = 1'b1);
    map_item_t it;
    it.op     = op;
    it.slot   = SLOT_W'(slot);
    it.pix    = PIX_W'(pix);
    it.mm     = MM_W'(mm);
    it.finite = finite;
    return it;
  endfunction

  // slots crowd a few entries near zero and near the limit so depths compete
  function automatic map_item_t random_map_item(int lim);
    map_item_t it;
    int roll;
    int rim_base;
    int slot;
    roll = $urandom_range(0, 99);
    it.op = roll < 55 ? OP_SCATTER : (roll < 90 ? OP_LOOKUP : OP_NOP);
    it.pix = PIX_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      slot = $urandom_range(0, 15);
    end else if (roll < 60) begin
      rim_base = lim > 8 ? lim - 8 : 0;
      slot = rim_base + $urandom_range(0, 15);
      if (slot > SLOT_TOP) slot = SLOT_TOP;
    end else if (roll < 75) begin
      slot = -1 - $urandom_range(0, SLOT_TOP);
    end else begin
      slot = $urandom_range(0, SLOT_TOP);
    end
    it.slot   = SLOT_W'(slot);
    it.mm     = $urandom_range(0, 99) < 70 ? MM_W'($urandom_range(0, 15)) : MM_W'($urandom);
    it.finite = $urandom_range(0, 99) < 90;
    return it;
  endfunction

  task automatic send_item(input map_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= it.op;
    depth_pixel  <= it.pix;
    color_slot   <= it.slot;
    depth_value  <= it.mm;
    depth_finite <= it.finite;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_results.size() != 0);
  endtask

  task automatic write_limit(input int lim);
    cfg_valid <= 1'b1;
    cfg_data  <= LIMIT_W'(lim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = lim;
  endtask

  initial begin
    tracker = new;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset limit still in force
    send_item(map_op(OP_LOOKUP, 0));
    send_item(map_op(OP_SCATTER, 0, 262143, 65535));
    send_item(map_op(OP_SCATTER, 0, 5, 65535));          // equal depth keeps the first
    send_item(map_op(OP_SCATTER, 0, 6, 1));
    send_item(map_op(OP_SCATTER, 0, 7, 0));              // zero depth dropped
    send_item(map_op(OP_SCATTER, 1, 8, 9, 1'b0));        // non-finite dropped
    send_item(map_op(OP_SCATTER, -1, 9, 9));
    send_item(map_op(OP_SCATTER, -COLOR_PIXELS, 9, 9));
    send_item(map_op(OP_SCATTER, LIMIT_RESET - 1, 0, 100));
    send_item(map_op(OP_SCATTER, LIMIT_RESET, 10, 1));
    send_item(map_op(OP_LOOKUP, 0));
    send_item(map_op(OP_LOOKUP, LIMIT_RESET - 1));
    send_item(map_op(OP_LOOKUP, LIMIT_RESET));
    send_item(map_op(OP_LOOKUP, -1));
    send_item(map_op(OP_NOP, 1, 262143, 1));
    send_item(map_op(OP_LOOKUP, 1));
    send_item(map_op(OP_CLEAR, 0));
    send_item(map_op(OP_LOOKUP, 0));
    send_item(map_op(OP_LOOKUP, LIMIT_RESET - 1));

    wait_for_results();
    write_limit(COLOR_PIXELS);
    send_item(map_op(OP_SCATTER, SLOT_TOP, 3, 65535));
    send_item(map_op(OP_LOOKUP, SLOT_TOP));

    // shrinking the limit hides entries without dropping them
    wait_for_results();
    write_limit(1);
    send_item(map_op(OP_LOOKUP, SLOT_TOP));
    send_item(map_op(OP_SCATTER, 0, 11, 2));
    send_item(map_op(OP_SCATTER, 1, 12, 1));
    send_item(map_op(OP_LOOKUP, 0));

    phase_limits = '{COLOR_PIXELS, 1, $urandom_range(2, 40), LIMIT_RESET, COLOR_PIXELS,
                     $urandom_range(41, COLOR_PIXELS)};
    for (int ph = 0; ph < 6; ph++) begin
      wait_for_results();
      write_limit(phase_limits[ph]);
      gaps_on = (ph != 4);
      repeat (255) send_item(random_map_item(cur_limit));
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
